// ===== rtl/core/occ_pkg.sv =====
// Shared types and codes for the occupancy grid ray update block.
package occ_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_W = 8;
    localparam int LIMIT_W = 17;
    localparam int STEP_W  = 14;
    localparam int BAND_W  = 15;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNK_BAND   = 2'd3;

    // Item actions.
    localparam logic ACT_RAY  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Cell classes.
    localparam logic [1:0] OCC_FREE     = 2'd0;
    localparam logic [1:0] OCC_OCCUPIED = 2'd1;
    localparam logic [1:0] OCC_UNKNOWN  = 2'd2;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                occupancy;
        logic signed [VALUE_W-1:0] cell_value;
        logic [COUNT_W-1:0]        cells_updated;
    } t_out_item;

    // Control from the sequencer to the squaring accumulator.
    typedef struct packed {
        logic load;
        logic accum;
    } t_sq_ctrl;

endpackage

// ===== rtl/core/occ_grid_ram.sv =====
// Grid cell memory: one write port and one registered read port.
module occ_grid_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/occ_sq_acc.sv =====
// Shared squaring unit with accumulator for the squared distance to the hit cell.
module occ_sq_acc
    import occ_pkg::*;
(
    input  logic                    i_clk,
    input  t_sq_ctrl                i_ctrl,
    input  logic signed [COORD_W:0] i_diff,
    output logic [LIMIT_W-1:0]      o_sum
);

    logic signed [2*COORD_W+1:0] prod;
    logic [LIMIT_W-1:0]          sq;
    logic [LIMIT_W-1:0]          r_sum;
    logic [LIMIT_W-1:0]          n_sum;

    // A square of a nine bit difference is below 2^16, so the sum of two fits.
    assign prod = i_diff * i_diff;
    assign sq   = prod[LIMIT_W-1:0];

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.load) begin
            n_sum = sq;
        end else if (i_ctrl.accum) begin
            n_sum = r_sum + sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/core/occupancy_grid_ray_update.sv =====
// Top level: sequencer, configuration and Bresenham walk of the occupancy grid.
//
//  Channel  Direction  Handshake             Payload
//  in       input      i_in_valid/o_in_stall   i_in_data   (t_in_item)
//  out      output     o_out_valid/i_out_stall o_out_data  (t_out_item)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A ray takes the transaction, visits max(|dx|,|dy|) cells and then gives the
// result transaction. Each cell costs a memory read, two passes through the
// shared squaring unit and a write-back.
// A read steps through take, address, data and result transaction. After
// reset every cell of the grid memory is cleared, one cell a cycle, while the
// input is stalled; configuration writes are taken.
// The output holds its transaction until i_out_stall is low; the input stays
// stalled until then.
module occupancy_grid_ray_update
    import occ_pkg::*;
#(
    parameter int GRID_SIDE = 256,
    parameter int CELL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Coordinates are eight bits wide, so only the first 256 rows and columns
    // can ever be reached.
    localparam int SIDE = (GRID_SIDE < 256) ? GRID_SIDE : 256;
    localparam int CW   = $clog2(SIDE);
    localparam int AW   = 2 * CW;
    localparam int SW   = ((CELL_BITS > STEP_W) ? CELL_BITS : STEP_W) + 1;
    localparam int MW   = (CELL_BITS + 1 > VALUE_W) ? CELL_BITS + 1 : VALUE_W;
    localparam longint CELL_MAX_L = (longint'(1) <<< (CELL_BITS - 1)) - 1;
    localparam logic signed [SW-1:0] CELL_MAX = SW'(CELL_MAX_L);
    localparam logic signed [SW-1:0] CELL_MIN = -CELL_MAX - SW'(1);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_CELL_RD   = 8'b0000_0100,
        S_CELL_DIST = 8'b0000_1000,
        S_CELL_UPD  = 8'b0001_0000,
        S_RD_ADDR   = 8'b0010_0000,
        S_RD_DATA   = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    logic [COORD_W-1:0]        r_maj, n_maj;
    logic [COORD_W-1:0]        r_mnr, n_mnr;
    logic signed [10:0]        r_err, n_err;
    logic [COORD_W-1:0]        r_steps, n_steps;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic                      r_xmaj, n_xmaj;
    logic                      r_maj_neg, n_maj_neg;
    logic                      r_min_neg, n_min_neg;
    logic [COORD_W:0]          r_two_dmaj, n_two_dmaj;
    logic [COORD_W:0]          r_two_dmin, n_two_dmin;
    logic [COORD_W-1:0]        r_ex, n_ex;
    logic [COORD_W-1:0]        r_ey, n_ey;
    t_out_item                 r_out, n_out;

    logic [LIMIT_W-1:0]        r_limit;
    logic signed [STEP_W-1:0]  r_close;
    logic signed [STEP_W-1:0]  r_far;
    logic [BAND_W-1:0]         r_band;

    // Ray set-up straight from the input item.
    logic signed [COORD_W:0]   dx, dy;
    logic [COORD_W-1:0]        adx, ady, dmaj, dmin;
    logic                      xm;
    logic signed [10:0]        err0;

    // Current cell.
    logic [COORD_W-1:0]        cx, cy;
    logic                      in_grid;
    logic [AW-1:0]             cell_addr;

    // Memory and arithmetic.
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [CELL_BITS-1:0]      wdata;
    logic [CELL_BITS-1:0]      rdata;
    t_sq_ctrl                  sq_ctrl;
    logic signed [COORD_W:0]   sq_diff;
    logic [LIMIT_W-1:0]        d2;
    logic signed [STEP_W-1:0]  step;
    logic signed [SW-1:0]      upd_sum;
    logic signed [SW-1:0]      upd_sat;
    logic signed [MW-1:0]      rd_val;
    logic signed [MW-1:0]      rd_mag;
    logic [1:0]                rd_cls;
    logic [COUNT_W-1:0]        count_inc;

    assign dx   = $signed({1'b0, i_in_data.end_x}) - $signed({1'b0, i_in_data.start_x});
    assign dy   = $signed({1'b0, i_in_data.end_y}) - $signed({1'b0, i_in_data.start_y});
    assign adx  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    assign ady  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    assign xm   = (adx >= ady);
    assign dmaj = xm ? adx : ady;
    assign dmin = xm ? ady : adx;
    assign err0 = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});

    assign cx        = r_xmaj ? r_maj : r_mnr;
    assign cy        = r_xmaj ? r_mnr : r_maj;
    assign in_grid   = ({1'b0, cx} < 9'(SIDE)) && ({1'b0, cy} < 9'(SIDE));
    assign cell_addr = {cx[CW-1:0], cy[CW-1:0]};

    assign sq_ctrl.load  = (r_state == S_CELL_RD);
    assign sq_ctrl.accum = (r_state == S_CELL_DIST);
    assign sq_diff = (r_state == S_CELL_RD)
                   ? $signed({1'b0, r_ex}) - $signed({1'b0, cx})
                   : $signed({1'b0, r_ey}) - $signed({1'b0, cy});

    occ_sq_acc u_sq (
        .i_clk  (i_clk),
        .i_ctrl (sq_ctrl),
        .i_diff (sq_diff),
        .o_sum  (d2)
    );

    // Log-odds update with saturation to the cell range.
    assign step    = (d2 <= r_limit) ? r_close : r_far;
    assign upd_sum = SW'($signed(rdata)) + SW'(step);
    always_comb begin
        if (upd_sum > CELL_MAX) begin
            upd_sat = CELL_MAX;
        end else if (upd_sum < CELL_MIN) begin
            upd_sat = CELL_MIN;
        end else begin
            upd_sat = upd_sum;
        end
    end

    // Read classification; a cell outside the grid reads as zero.
    assign rd_val = in_grid ? MW'($signed(rdata)) : '0;
    assign rd_mag = rd_val[MW-1] ? -rd_val : rd_val;
    always_comb begin
        if (rd_mag <= $signed(MW'(r_band))) begin
            rd_cls = OCC_UNKNOWN;
        end else if (rd_val[MW-1]) begin
            rd_cls = OCC_FREE;
        end else begin
            rd_cls = OCC_OCCUPIED;
        end
    end

    assign we    = (r_state == S_CLEAR) || ((r_state == S_CELL_UPD) && in_grid);
    assign waddr = (r_state == S_CLEAR) ? r_clr : cell_addr;
    assign wdata = (r_state == S_CLEAR) ? '0 : upd_sat[CELL_BITS-1:0];

    occ_grid_ram #(
        .ADDR_W (AW),
        .DATA_W (CELL_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (cell_addr),
        .o_rdata (rdata)
    );

    assign count_inc = r_count + COUNT_W'(in_grid);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_maj      = r_maj;
        n_mnr      = r_mnr;
        n_err      = r_err;
        n_steps    = r_steps;
        n_count    = r_count;
        n_xmaj     = r_xmaj;
        n_maj_neg  = r_maj_neg;
        n_min_neg  = r_min_neg;
        n_two_dmaj = r_two_dmaj;
        n_two_dmin = r_two_dmin;
        n_ex       = r_ex;
        n_ey       = r_ey;
        n_out      = r_out;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == ACT_READ) begin
                        n_xmaj  = 1'b1;
                        n_maj   = i_in_data.start_x;
                        n_mnr   = i_in_data.start_y;
                        n_state = S_RD_ADDR;
                    end else begin
                        n_xmaj     = xm;
                        n_maj      = xm ? i_in_data.start_x : i_in_data.start_y;
                        n_mnr      = xm ? i_in_data.start_y : i_in_data.start_x;
                        n_maj_neg  = xm ? dx[COORD_W] : dy[COORD_W];
                        n_min_neg  = xm ? dy[COORD_W] : dx[COORD_W];
                        n_two_dmaj = {dmaj, 1'b0};
                        n_two_dmin = {dmin, 1'b0};
                        n_err      = err0;
                        n_steps    = dmaj;
                        n_count    = '0;
                        n_ex       = i_in_data.end_x;
                        n_ey       = i_in_data.end_y;
                        if (dmaj == '0) begin
                            n_out   = '0;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_CELL_RD;
                        end
                    end
                end
            end
            S_CELL_RD: begin
                n_state = S_CELL_DIST;
            end
            S_CELL_DIST: begin
                n_state = S_CELL_UPD;
            end
            S_CELL_UPD: begin
                n_count = count_inc;
                // The minor axis steps after the cell is visited.
                if (r_err > 0) begin
                    n_mnr = r_min_neg ? r_mnr - 1'b1 : r_mnr + 1'b1;
                    n_err = r_err - $signed({2'b00, r_two_dmaj})
                                  + $signed({2'b00, r_two_dmin});
                end else begin
                    n_err = r_err + $signed({2'b00, r_two_dmin});
                end
                n_maj   = r_maj_neg ? r_maj - 1'b1 : r_maj + 1'b1;
                n_steps = r_steps - 1'b1;
                if (r_steps == COORD_W'(1)) begin
                    n_out.occupancy     = OCC_FREE;
                    n_out.cell_value    = '0;
                    n_out.cells_updated = count_inc;
                    n_state             = S_OUT;
                end else begin
                    n_state = S_CELL_RD;
                end
            end
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_out.occupancy     = rd_cls;
                n_out.cell_value    = rd_val[VALUE_W-1:0];
                n_out.cells_updated = '0;
                n_state             = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_maj   <= '0;
            r_mnr   <= '0;
            r_err   <= '0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_maj   <= n_maj;
            r_mnr   <= n_mnr;
            r_err   <= n_err;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_xmaj     <= n_xmaj;
        r_maj_neg  <= n_maj_neg;
        r_min_neg  <= n_min_neg;
        r_two_dmaj <= n_two_dmaj;
        r_two_dmin <= n_two_dmin;
        r_ex       <= n_ex;
        r_ey       <= n_ey;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(4);
            r_close <= STEP_W'(2048);
            r_far   <= -STEP_W'(512);
            r_band  <= BAND_W'(512);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIT_LIMIT:  r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_CLOSE_STEP: r_close <= $signed(i_cfg_data[STEP_W-1:0]);
                CFG_FAR_STEP:   r_far   <= $signed(i_cfg_data[STEP_W-1:0]);
                CFG_UNK_BAND:   r_band  <= i_cfg_data[BAND_W-1:0];
                default:        r_limit <= r_limit;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

// ===== sim/tb_occupancy_grid_ray_update.sv =====
// Self-checking testbench for the occupancy grid ray update block.
`timescale 1ns / 100ps

module tb_occupancy_grid_ray_update;
    import occ_pkg::*;

    localparam int GRID_SIDE   = 256;
    localparam int CELL_MAX    = 32767;
    localparam int CELL_MIN    = -32768;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 400;

    // Keeps a copy of the grid and the registers, predicts each result and
    // compares it with what the block returns.
    class grid_tracker;
        int cell_log_odds[GRID_SIDE * GRID_SIDE];
        int hit_limit;
        int close_inc;
        int far_inc;
        int band;
        t_out_item pending_results[$];
        int errors;
        int rays;
        int reads;
        int walked;
        int classes_seen[3];

        function new();
            foreach (cell_log_odds[k]) cell_log_odds[k] = 0;
            hit_limit = 4;
            close_inc = 2048;
            far_inc   = -512;
            band      = 512;
            errors    = 0;
            rays      = 0;
            reads     = 0;
            walked    = 0;
            foreach (classes_seen[c]) classes_seen[c] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HIT_LIMIT:  hit_limit = int'(data);
                CFG_CLOSE_STEP: close_inc = int'($signed(data[STEP_W-1:0]));
                CFG_FAR_STEP:   far_inc   = int'($signed(data[STEP_W-1:0]));
                CFG_UNK_BAND:   band      = int'(data[BAND_W-1:0]);
                default: ;
            endcase
        endfunction

        // Adds the close or far step to one cell and clamps it to the cell range.
        function bit bump_cell(int x, int y, int hx, int hy);
            int ddx;
            int ddy;
            int d2;
            int v;
            if (x >= GRID_SIDE || y >= GRID_SIDE) return 0;
            ddx = hx - x;
            ddy = hy - y;
            d2  = ddx * ddx + ddy * ddy;
            v   = cell_log_odds[x * GRID_SIDE + y] + ((d2 <= hit_limit) ? close_inc : far_inc);
            if (v > CELL_MAX) v = CELL_MAX;
            if (v < CELL_MIN) v = CELL_MIN;
            cell_log_odds[x * GRID_SIDE + y] = v;
            return 1;
        endfunction

        function t_out_item trace_ray(t_in_item it);
            t_out_item res;
            int dx;
            int dy;
            int adx;
            int ady;
            int dmaj;
            int dmin;
            int smaj;
            int smin;
            int maj;
            int mnr;
            int err;
            int count;
            bit x_major;
            bit hit;
            dx = int'(it.end_x) - int'(it.start_x);
            dy = int'(it.end_y) - int'(it.start_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            // On a tie the x axis leads.
            x_major = (adx >= ady);
            dmaj = x_major ? adx : ady;
            dmin = x_major ? ady : adx;
            smaj = x_major ? ((dx < 0) ? -1 : 1) : ((dy < 0) ? -1 : 1);
            smin = x_major ? ((dy < 0) ? -1 : 1) : ((dx < 0) ? -1 : 1);
            maj  = x_major ? int'(it.start_x) : int'(it.start_y);
            mnr  = x_major ? int'(it.start_y) : int'(it.start_x);
            err  = 2 * dmin - dmaj;
            count = 0;
            // The start cell is visited and the walk stops short of the hit cell.
            for (int n = 0; n < dmaj; n++) begin
                if (x_major) begin
                    hit = bump_cell(maj, mnr, int'(it.end_x), int'(it.end_y));
                end else begin
                    hit = bump_cell(mnr, maj, int'(it.end_x), int'(it.end_y));
                end
                if (hit) count++;
                if (err > 0) begin
                    mnr += smin;
                    err -= 2 * dmaj;
                end
                err += 2 * dmin;
                maj += smaj;
            end
            rays++;
            walked += count;
            res.occupancy     = OCC_FREE;
            res.cell_value    = '0;
            res.cells_updated = COUNT_W'(count);
            return res;
        endfunction

        function t_out_item read_cell(t_in_item it);
            t_out_item res;
            int v;
            int mag;
            logic [1:0] cls;
            v = 0;
            if (it.start_x < GRID_SIDE && it.start_y < GRID_SIDE) begin
                v = cell_log_odds[int'(it.start_x) * GRID_SIDE + int'(it.start_y)];
            end
            mag = (v < 0) ? -v : v;
            // A cell inside the band reads unknown, even with a zero band.
            if (mag <= band) cls = OCC_UNKNOWN;
            else if (v < 0)  cls = OCC_FREE;
            else             cls = OCC_OCCUPIED;
            reads++;
            classes_seen[cls]++;
            res.occupancy     = cls;
            res.cell_value    = VALUE_W'(v);
            res.cells_updated = '0;
            return res;
        endfunction

        function void record_item(t_in_item it);
            if (it.action == ACT_READ) pending_results = {pending_results, read_cell(it)};
            else                       pending_results = {pending_results, trace_ray(it)};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with nothing pending");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
            if (got.cell_value !== want.cell_value) begin
                $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
                errors++;
            end
            if (got.cells_updated !== want.cells_updated) begin
                $error("cells_updated: expected %0d, got %0d",
                       want.cells_updated, got.cells_updated);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    grid_tracker tracker;
    bit quiet             = 0;
    bit long_hold_request = 0;
    int settings_used     = 1;
    int cycles            = 0;

    occupancy_grid_ray_update dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timed out after %0d cycles.", cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: checks each accepted transaction and stalls in bursts,
    // plus one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int burst;
        int hold_cycles;
        burst = 0;
        hold_cycles = 0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0) tracker.check_result(out_data);
            if (hold_cycles > 0) begin
                hold_cycles--;
            end else if (long_hold_request) begin
                hold_cycles = LONG_HOLD;
                long_hold_request = 0;
            end
            if (burst > 0) begin
                burst--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4);
            end
            out_stall <= (hold_cycles > 0) || (burst > 0);
        end
    end

    function automatic t_in_item make_item(logic action, int sx, int sy, int ex, int ey);
        t_in_item it;
        it.action  = action;
        it.start_x = COORD_W'(sx);
        it.start_y = COORD_W'(sy);
        it.end_x   = COORD_W'(ex);
        it.end_y   = COORD_W'(ey);
        return it;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > GRID_SIDE - 1) return GRID_SIDE - 1;
        return v;
    endfunction

    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        tracker.record_item(it);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_settings(int limit, int close_s, int far_s, int band_w);
        write_register(CFG_HIT_LIMIT, limit);
        write_register(CFG_CLOSE_STEP, close_s);
        write_register(CFG_FAR_STEP, far_s);
        write_register(CFG_UNK_BAND, band_w);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
    endtask

    // Mostly short rays and reads around a hot window so that cells build up
    // and cross the class thresholds; a few long rays and reads anywhere on the grid.
    task automatic run_random(int count, int hot_x, int hot_y);
        t_in_item it;
        int pick;
        int sx;
        int sy;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            sx = hot_x + $urandom_range(0, 31);
            sy = hot_y + $urandom_range(0, 31);
            if (pick < 5) begin
                it = make_item(ACT_RAY, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (pick < 7) begin
                it = make_item(ACT_RAY, sx, sy, sx, sy);
            end else if (pick < 60) begin
                it = make_item(ACT_RAY, sx, sy,
                               clamp_coord(sx + $urandom_range(0, 24) - 12),
                               clamp_coord(sy + $urandom_range(0, 24) - 12));
            end else if (pick < 88) begin
                it = make_item(ACT_READ, sx, sy, $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                it = make_item(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
            end
            send_item(it);
        end
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: close step near the hit, far step elsewhere.
        send_item(make_item(ACT_READ, 0, 0, 255, 255));
        send_item(make_item(ACT_RAY, 5, 5, 5, 5));
        send_item(make_item(ACT_RAY, 0, 0, 255, 255));
        send_item(make_item(ACT_RAY, 255, 0, 0, 255));
        send_item(make_item(ACT_RAY, 10, 10, 20, 13));
        send_item(make_item(ACT_RAY, 30, 30, 28, 50));
        send_item(make_item(ACT_RAY, 100, 100, 104, 100));
        send_item(make_item(ACT_RAY, 100, 100, 104, 100));
        send_item(make_item(ACT_READ, 103, 100, 0, 0));
        send_item(make_item(ACT_READ, 100, 100, 0, 0));
        send_item(make_item(ACT_READ, 0, 0, 0, 0));
        send_item(make_item(ACT_READ, 255, 255, 0, 0));
        wait_drained();

        // Far step at its negative extreme drives cells to the lower clamp.
        apply_settings(0, 8191, -8192, 0);
        repeat (5) send_item(make_item(ACT_RAY, 50, 50, 50, 58));
        send_item(make_item(ACT_READ, 50, 50, 0, 0));
        send_item(make_item(ACT_READ, 7, 7, 0, 0));
        run_random(220, $urandom_range(0, 224), $urandom_range(0, 224));
        wait_drained();

        // Every cell counts as close; the upper clamp meets the widest band.
        apply_settings(131071, 8191, 8191, 32767);
        repeat (5) send_item(make_item(ACT_RAY, 60, 60, 66, 61));
        send_item(make_item(ACT_READ, 60, 60, 0, 0));
        send_item(make_item(ACT_READ, 50, 50, 0, 0));
        run_random(220, $urandom_range(0, 224), $urandom_range(0, 224));
        wait_drained();

        apply_settings($urandom_range(0, 131071), int'($urandom_range(0, 16383)) - 8192,
                       int'($urandom_range(0, 16383)) - 8192, $urandom_range(0, 32767));
        run_random(110, $urandom_range(0, 224), $urandom_range(0, 224));
        long_hold_request = 1;
        run_random(110, $urandom_range(0, 224), $urandom_range(0, 224));
        wait_drained();

        apply_settings(9, 700, -250, 400);
        run_random(120, $urandom_range(0, 224), $urandom_range(0, 224));
        quiet = 1;
        run_random(120, $urandom_range(0, 224), $urandom_range(0, 224));
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Traced %0d rays over %0d cells and read %0d cells under %0d register settings.",
                 tracker.rays, tracker.walked, tracker.reads, settings_used);
        $display("Reads returned %0d free, %0d occupied and %0d unknown cells.",
                 tracker.classes_seen[OCC_FREE], tracker.classes_seen[OCC_OCCUPIED],
                 tracker.classes_seen[OCC_UNKNOWN]);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/occ_pkg.sv
rtl/core/occ_grid_ram.sv
rtl/core/occ_sq_acc.sv
rtl/core/occupancy_grid_ray_update.sv
sim/tb_occupancy_grid_ray_update.sv
